// ===== hw/rtl/pcr_pkg.sv =====
// Shared types and constants of the parameter command responder.
package pcr_pkg;

  // Command function codes
  localparam logic [7:0] FN_READ  = 8'hE1;
  localparam logic [7:0] FN_WRITE = 8'hE2;

  // Reply frame header bytes
  localparam logic [7:0] HDR_SYNC      = 8'hAA;
  localparam logic [7:0] HDR_PARAM     = 8'hAF;
  localparam logic [7:0] HDR_CHECK     = 8'hFF;
  localparam logic [7:0] HDR_ZERO      = 8'h00;
  localparam logic [7:0] PARAM_PAY_LEN = 8'h06;
  localparam logic [7:0] CHECK_PAY_LEN = 8'h03;
  localparam logic [7:0] PARAM_FN_CODE = 8'hE2;

  // Lowest parameter ID held by the store
  localparam logic [15:0] FIRST_ID = 16'd10;

  // Leading bytes before the two check bytes
  localparam int FRAME_BYTES = 10;
  localparam int CNT_W       = 4;
  localparam logic [CNT_W-1:0] READ_LEN  = 4'd10;
  localparam logic [CNT_W-1:0] WRITE_LEN = 4'd7;

  typedef struct packed {
    logic [7:0]         frame_function;
    logic [15:0]        param_id;
    logic signed [31:0] param_value;
    logic [7:0]         rx_sum_check;
    logic [7:0]         rx_add_check;
  } pcr_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } pcr_out_t;

  // Frame handed to the transmit shifter; byte 0 goes out first
  typedef struct packed {
    logic                             vld;
    logic [CNT_W-1:0]                 len;
    logic [FRAME_BYTES-1:0][7:0]      bytes;
  } pcr_load_t;

endpackage

// ===== hw/rtl/pcr_tx.sv =====
// Byte-serial frame transmitter that appends the sum and add check bytes.
module pcr_tx
  import pcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pcr_load_t load,
  output logic      idle,
  output logic      out_valid,
  input  logic      out_ready,
  output pcr_out_t  out_data
);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [FRAME_BYTES-1:0][7:0] sh_r, sh_nxt;
  logic [7:0]                  sc_r, sc_nxt;
  logic [7:0]                  ac_r, ac_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pcr_out_t                    out_data_r, out_data_nxt;
  logic                        adv;

  assign idle      = (cnt_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Advance one byte when one is pending and the output register is free
  assign adv = !idle && (!out_valid_r || out_ready);

  always_comb begin
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    sc_nxt        = sc_r;
    ac_nxt        = ac_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load.vld && idle) begin
      // Take a new frame: leading bytes plus two check bytes
      cnt_nxt = load.len + CNT_W'(2);
      sh_nxt  = load.bytes;
      sc_nxt  = '0;
      ac_nxt  = '0;
    end
    if (adv) begin
      cnt_nxt       = cnt_r - CNT_W'(1);
      out_valid_nxt = 1'b1;
      if (cnt_r > CNT_W'(2)) begin
        // Shift out a leading byte and fold it into the running checks
        out_data_nxt.tx_byte   = sh_r[0];
        out_data_nxt.frame_end = 1'b0;
        sc_nxt                 = sc_r + sh_r[0];
        ac_nxt                 = ac_r + sc_r + sh_r[0];
        sh_nxt                 = {8'h00, sh_r[FRAME_BYTES-1:1]};
      end else if (cnt_r == CNT_W'(2)) begin
        out_data_nxt.tx_byte   = sc_r;
        out_data_nxt.frame_end = 1'b0;
      end else begin
        out_data_nxt.tx_byte   = ac_r;
        out_data_nxt.frame_end = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    sc_r       <= sc_nxt;
    ac_r       <= ac_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/parameter_command_responder.sv =====
// Top level of the parameter command responder: parameter store and command decode.
// Holds PARAM_COUNT signed 32-bit parameters at IDs 10 and up, cleared by reset.
// A read command (E1) of a known ID answers with a 12-byte parameter frame, a
// write command (E2) answers with a 9-byte check frame and then stores the value
// if the ID is known; anything else is taken and answers nothing.
// Reply bytes leave one per cycle from the transmit shift register while
// out_ready is high; in_ready stays low while that register still holds
// reply bytes. A command is taken as soon as the shift register has sent its
// last byte, while that byte may still wait in the output register.
module parameter_command_responder
  import pcr_pkg::*;
#(
  parameter int PARAM_COUNT = 5
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pcr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pcr_out_t out_data
);

  localparam int SLOT_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  logic [31:0]       store_r [PARAM_COUNT];
  logic              tx_idle;
  logic              in_xfer;
  logic [15:0]       id_off;
  logic              known;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       rd_data;
  pcr_load_t         load;

  assign in_ready = tx_idle;
  assign in_xfer  = in_valid && in_ready;

  // Map the ID onto a store slot
  assign id_off = in_data.param_id - FIRST_ID;
  assign known  = (in_data.param_id >= FIRST_ID) && (id_off < 16'(PARAM_COUNT));
  assign slot   = id_off[SLOT_W-1:0];
  assign rd_data = known ? store_r[slot] : '0;

  // Build the leading bytes of the reply frame
  always_comb begin
    load       = '0;
    load.bytes[0] = HDR_SYNC;
    case (in_data.frame_function)
      FN_READ: begin
        load.vld      = in_xfer && known;
        load.len      = READ_LEN;
        load.bytes[1] = HDR_PARAM;
        load.bytes[2] = PARAM_FN_CODE;
        load.bytes[3] = PARAM_PAY_LEN;
        load.bytes[4] = in_data.param_id[7:0];
        load.bytes[5] = in_data.param_id[15:8];
        load.bytes[6] = rd_data[7:0];
        load.bytes[7] = rd_data[15:8];
        load.bytes[8] = rd_data[23:16];
        load.bytes[9] = rd_data[31:24];
      end
      FN_WRITE: begin
        load.vld      = in_xfer;
        load.len      = WRITE_LEN;
        load.bytes[1] = HDR_CHECK;
        load.bytes[2] = HDR_ZERO;
        load.bytes[3] = CHECK_PAY_LEN;
        load.bytes[4] = FN_WRITE;
        load.bytes[5] = in_data.rx_sum_check;
        load.bytes[6] = in_data.rx_add_check;
      end
      default: begin
        load.vld = 1'b0;
      end
    endcase
  end

  // Store a written value; clear all parameters at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARAM_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else if (in_xfer && known && (in_data.frame_function == FN_WRITE)) begin
      store_r[slot] <= in_data.param_value;
    end
  end

  pcr_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .idle      (tx_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/pcr_chk.sv =====
// Port-level checker for the parameter command responder, bound to the top level.
module pcr_chk
  import pcr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input pcr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input pcr_out_t out_data
);

  // A stalled reply byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("reply byte changed while stalled");

  // No command is taken while a frame is mid-flight
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_end |-> !in_ready)
    else $error("command taken in the middle of a reply frame");

  // A write command taken while the output is not stalled starts a check frame with the sync byte
  a_write_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.frame_function == FN_WRITE) &&
    (!out_valid || out_ready)
    |=> !in_ready ##1 (out_valid && (out_data.tx_byte == HDR_SYNC) &&
                       !out_data.frame_end))
    else $error("write command did not start a check frame");

  // Nothing is shown straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("reply valid right after reset");

endmodule

bind parameter_command_responder pcr_chk u_pcr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
